// ===== sv/i2cst_pkg.sv =====
// package: transaction layouts, phase codes and counter constants for the i2c slave fsm
`timescale 1ns / 1ps

package i2cst_pkg;

    // bus widths, whole bytes
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ADDR     = 3'd1;
    localparam logic [2:0] PH_ADDR_ACK = 3'd2;
    localparam logic [2:0] PH_WRITE    = 3'd3;
    localparam logic [2:0] PH_WR_ACK   = 3'd4;
    localparam logic [2:0] PH_READ     = 3'd5;
    localparam logic [2:0] PH_RD_ACK   = 3'd6;
    localparam logic [2:0] PH_ERROR    = 3'd7;

    // bit counter marks
    localparam logic [3:0] LAST_DATA_BIT = 4'd7;
    localparam logic [3:0] ACK_BIT       = 4'd8;
    localparam logic [3:0] COUNT_CLEAR   = 4'd15;

    // input transaction, lowest field last
    typedef struct packed {
        logic [6:0] pad;
        logic       soft_clear;
        logic       addr_nack;
        logic       rw_bit;
        logic       scl_fall;
        logic       scl_rise;
        logic       scl_level;
        logic       sda_fall;
        logic       sda_rise;
        logic       sda_level;
    } in_item_t;

    // result transaction, lowest field last
    typedef struct packed {
        logic       ack_done;
        logic       bus_error;
        logic       in_read_ack;
        logic       in_write_ack;
        logic       in_write_byte;
        logic       in_read_byte;
        logic       in_addr_ack;
        logic       in_addr_byte;
        logic [7:0] state_onehot;
    } out_item_t;

endpackage

// ===== sv/i2c_slave_transfer_fsm.sv =====
// top level: i2c slave transfer state machine with registered input and result stages
`timescale 1ns / 1ps

// I2C slave transfer state machine.
// The s_ channel carries one transaction per system clock with the sampled
// SDA/SCL levels and edge flags, the received direction bit, an address
// mismatch flag and a soft clear. The m_ channel returns one transaction for
// each input: the one-hot phase and phase strobes as held before that input,
// plus ack_done (SCL rise on the acknowledge bit).
// An accepted input passes the input register, then the phase/counter update
// into the result register, where m_tvalid rises; a full result register that
// m_tready does not drain holds it in the input register. The block takes one
// transaction per cycle while the receiver does not stall it.
// s_tready stays high while the result register is empty or being drained, so
// a new input is taken even while a finished result waits on m_tready. When
// the receiver stalls, the result holds and one more input is buffered, after
// which s_tready drops.
// Reset (aresetn low, synchronous) empties both stages, sets the phase to
// idle and the bit counter to 15.
module i2c_slave_transfer_fsm (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // sda_level, sda_rise, sda_fall, scl_level, scl_rise, scl_fall, rw_bit,
    // addr_nack, soft_clear, zero fill
    input  logic [i2cst_pkg::IN_W-1:0]   s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // state_onehot[7:0], in_addr_byte, in_addr_ack, in_read_byte,
    // in_write_byte, in_write_ack, in_read_ack, bus_error, ack_done
    output logic [i2cst_pkg::OUT_W-1:0]  m_tdata
);
    import i2cst_pkg::*;

    logic             in_valid_reg;
    in_item_t         in_item_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic [2:0]       phase_reg;
    logic [2:0]       phase_next;
    logic [3:0]       cnt_reg;
    logic [3:0]       cnt_next;
    logic             advance;
    logic             start;
    logic             stop;
    logic             byte_done;
    logic             ack_done;
    out_item_t        result;

    // stage handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;

    // bus conditions from the buffered transaction
    assign start     = in_item_reg.sda_fall && in_item_reg.scl_level;
    assign stop      = in_item_reg.sda_rise && in_item_reg.scl_level;
    assign byte_done = in_item_reg.scl_rise && (cnt_reg == LAST_DATA_BIT);
    assign ack_done  = in_item_reg.scl_rise && (cnt_reg == ACK_BIT);

    // result fields from the held phase
    always_comb begin
        result               = '0;
        result.state_onehot  = 8'b1 << phase_reg;
        result.in_addr_byte  = (phase_reg == PH_ADDR);
        result.in_addr_ack   = (phase_reg == PH_ADDR_ACK);
        result.in_read_byte  = (phase_reg == PH_READ);
        result.in_write_byte = (phase_reg == PH_WRITE) || (phase_reg == PH_ADDR);
        result.in_write_ack  = (phase_reg == PH_WR_ACK) || (phase_reg == PH_ADDR_ACK);
        result.in_read_ack   = (phase_reg == PH_RD_ACK);
        result.bus_error     = (phase_reg == PH_ERROR);
        result.ack_done      = ack_done;
    end

    // phase transitions
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE: begin
                if (start) phase_next = PH_ADDR;
            end
            PH_ADDR: begin
                if (byte_done)  phase_next = PH_ADDR_ACK;
                else if (stop)  phase_next = PH_ERROR;
            end
            PH_ADDR_ACK: begin
                if (in_item_reg.addr_nack)  phase_next = PH_IDLE;
                else if (ack_done)          phase_next = in_item_reg.rw_bit ? PH_READ : PH_WRITE;
                else if (start || stop)     phase_next = PH_ERROR;
            end
            PH_WRITE: begin
                if (byte_done)   phase_next = PH_WR_ACK;
                else if (start)  phase_next = PH_ADDR;
                else if (stop)   phase_next = PH_IDLE;
            end
            PH_WR_ACK: begin
                if (ack_done)               phase_next = PH_WRITE;
                else if (start || stop)     phase_next = PH_ERROR;
            end
            PH_READ: begin
                if (byte_done)   phase_next = PH_RD_ACK;
                else if (start)  phase_next = PH_ADDR;
                else if (stop)   phase_next = PH_IDLE;
            end
            PH_RD_ACK: begin
                // master nack ends the read
                if (ack_done)           phase_next = in_item_reg.sda_level ? PH_IDLE : PH_READ;
                else if (start || stop) phase_next = PH_ERROR;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
        if (in_item_reg.soft_clear) phase_next = PH_IDLE;
    end

    // bit counter update
    always_comb begin
        cnt_next = cnt_reg;
        if (in_item_reg.soft_clear || ack_done || start) cnt_next = COUNT_CLEAR;
        else if (in_item_reg.scl_fall)                   cnt_next = cnt_reg + 4'd1;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            cnt_reg       <= COUNT_CLEAR;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) in_item_reg <= in_item_t'(s_tdata);
        if (advance)              out_item_reg <= result;
    end

    // result always shows exactly one phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot(out_item_reg.state_onehot))
        else $error("state_onehot is not one-hot");

    // soft clear returns phase and counter to their reset values
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.soft_clear) |=> (phase_reg == PH_IDLE && cnt_reg == COUNT_CLEAR))
        else $error("soft clear did not reset phase and counter");

    // an acknowledge clock reloads the counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && ack_done) |=> (cnt_reg == COUNT_CLEAR))
        else $error("counter not reloaded after ack");

    // a buffered input is never dropped while the result stage is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("buffered input lost during stall");

endmodule

// ===== verif/i2c_fsm_checker.sv =====
// checker: predicts and compares the status transactions of the i2c slave transfer fsm
`timescale 1ns / 1ps

module i2c_fsm_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    // sda_level, sda_rise, sda_fall, scl_level, scl_rise, scl_fall, rw_bit,
    // addr_nack, soft_clear, zero fill
    input  logic [i2cst_pkg::IN_W-1:0]  s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    // state_onehot[7:0], in_addr_byte, in_addr_ack, in_read_byte,
    // in_write_byte, in_write_ack, in_read_ack, bus_error, ack_done
    input  logic [i2cst_pkg::OUT_W-1:0] m_tdata,
    output int                          fail_count,
    output int                          pending
);

    import i2cst_pkg::*;

    // own copy of the fsm state
    logic [2:0] model_phase;
    logic [3:0] model_bits;

    // status transactions still to come, oldest first
    out_item_t status_fifo[$];
    int        mismatches;

    // one system-clock step: status as held before the input, then the update
    task automatic step_transfer_fsm(input in_item_t it, output out_item_t res);
        logic       start_c;
        logic       stop_c;
        logic       byte_done;
        logic       ack_done;
        logic [2:0] nxt;
        start_c   = it.sda_fall & it.scl_level;
        stop_c    = it.sda_rise & it.scl_level;
        byte_done = it.scl_rise && (model_bits == LAST_DATA_BIT);
        ack_done  = it.scl_rise && (model_bits == ACK_BIT);

        res.state_onehot  = 8'b1 << model_phase;
        res.in_addr_byte  = (model_phase == PH_ADDR);
        res.in_addr_ack   = (model_phase == PH_ADDR_ACK);
        res.in_read_byte  = (model_phase == PH_READ);
        res.in_write_byte = (model_phase == PH_WRITE) || (model_phase == PH_ADDR);
        res.in_write_ack  = (model_phase == PH_WR_ACK) || (model_phase == PH_ADDR_ACK);
        res.in_read_ack   = (model_phase == PH_RD_ACK);
        res.bus_error     = (model_phase == PH_ERROR);
        res.ack_done      = ack_done;

        // phase transitions
        nxt = model_phase;
        case (model_phase)
            PH_IDLE: begin
                if (start_c) nxt = PH_ADDR;
            end
            PH_ADDR: begin
                if (byte_done) nxt = PH_ADDR_ACK;
                else if (stop_c) nxt = PH_ERROR;
            end
            PH_ADDR_ACK: begin
                // address mismatch wins over everything else
                if (it.addr_nack) nxt = PH_IDLE;
                else if (ack_done) nxt = it.rw_bit ? PH_READ : PH_WRITE;
                else if (start_c || stop_c) nxt = PH_ERROR;
            end
            PH_WRITE: begin
                if (byte_done) nxt = PH_WR_ACK;
                else if (start_c) nxt = PH_ADDR;
                else if (stop_c) nxt = PH_IDLE;
            end
            PH_WR_ACK: begin
                if (ack_done) nxt = PH_WRITE;
                else if (start_c || stop_c) nxt = PH_ERROR;
            end
            PH_READ: begin
                if (byte_done) nxt = PH_RD_ACK;
                else if (start_c) nxt = PH_ADDR;
                else if (stop_c) nxt = PH_IDLE;
            end
            PH_RD_ACK: begin
                // master nack ends the read
                if (ack_done) nxt = it.sda_level ? PH_IDLE : PH_READ;
                else if (start_c || stop_c) nxt = PH_ERROR;
            end
            default: begin
                nxt = PH_IDLE;
            end
        endcase

        // bit counter, wraps past 15
        if (it.soft_clear || ack_done || start_c) model_bits = COUNT_CLEAR;
        else if (it.scl_fall) model_bits = model_bits + 4'd1;

        model_phase = it.soft_clear ? PH_IDLE : nxt;
    endtask

    // watch both channels at the rising edge
    always @(posedge aclk) begin
        out_item_t got;
        out_item_t want;
        if (!aresetn) begin
            model_phase = PH_IDLE;
            model_bits  = COUNT_CLEAR;
            status_fifo.delete();
            mismatches  = 0;
        end else begin
            // result side first: a result never belongs to the input of the same edge
            if (m_tvalid && m_tready) begin
                got = out_item_t'(m_tdata);
                if (status_fifo.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected status transaction %h", $time, m_tdata);
                end else begin
                    want = status_fifo.pop_front();
                    if (got.state_onehot !== want.state_onehot ||
                        got.in_addr_byte !== want.in_addr_byte ||
                        got.in_addr_ack !== want.in_addr_ack ||
                        got.in_read_byte !== want.in_read_byte ||
                        got.in_write_byte !== want.in_write_byte ||
                        got.in_write_ack !== want.in_write_ack ||
                        got.in_read_ack !== want.in_read_ack ||
                        got.bus_error !== want.bus_error ||
                        got.ack_done !== want.ack_done) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: status mismatch: expected state=%b strobes=%b ack=%b",
                                $time, want.state_onehot,
                                {want.in_addr_byte, want.in_addr_ack, want.in_read_byte,
                                 want.in_write_byte, want.in_write_ack, want.in_read_ack,
                                 want.bus_error}, want.ack_done);
                            $display("    got state=%b strobes=%b ack=%b",
                                got.state_onehot,
                                {got.in_addr_byte, got.in_addr_ack, got.in_read_byte,
                                 got.in_write_byte, got.in_write_ack, got.in_read_ack,
                                 got.bus_error}, got.ack_done);
                        end
                    end
                end
            end
            // input side
            if (s_tvalid && s_tready) begin
                step_transfer_fsm(in_item_t'(s_tdata), want);
                status_fifo.push_back(want);
            end
        end
        fail_count <= mismatches;
        pending    <= status_fifo.size();
    end

endmodule

// ===== verif/testbench.sv =====
// testbench top: clock, reset, bus-level stimulus and verdict for the i2c slave transfer fsm
`timescale 1ns / 1ps

module testbench;

    import i2cst_pkg::*;

    localparam int NUM_ITEMS  = 1200;
    localparam int IDLE_LIMIT = 500;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;

    // bus levels as last sent, and per-frame sideband
    logic bus_sda;
    logic bus_scl;
    logic frame_rw;
    logic frame_nack;
    logic no_idle;
    int   items_sent;
    int   idle_cycles;

    i2c_slave_transfer_fsm u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    i2c_fsm_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // one input transaction, called at a falling edge, returns at a falling edge
    task automatic send_item(input in_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    // move the bus to new levels, edges follow from the previous levels
    task automatic drive_bus(input logic sda, input logic scl);
        in_item_t it;
        int       holds;
        it            = '0;
        it.sda_level  = sda;
        it.sda_rise   = sda & ~bus_sda;
        it.sda_fall   = ~sda & bus_sda;
        it.scl_level  = scl;
        it.scl_rise   = scl & ~bus_scl;
        it.scl_fall   = ~scl & bus_scl;
        it.rw_bit     = frame_rw;
        it.addr_nack  = frame_nack;
        it.soft_clear = ($urandom_range(0, 127) == 0);
        bus_sda = sda;
        bus_scl = scl;
        send_item(it);
        // occasionally hold the levels a little longer
        holds = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        it.sda_rise   = 1'b0;
        it.sda_fall   = 1'b0;
        it.scl_rise   = 1'b0;
        it.scl_fall   = 1'b0;
        it.soft_clear = 1'b0;
        repeat (holds) send_item(it);
    endtask

    // result side: random stall before each result
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial begin
        in_item_t it;
        int       pick;
        int       nbytes;
        int       total_bits;
        int       abort_at;
        int       n;
        logic     broken;
        logic     bit_val;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        bus_sda    = 1'b1;
        bus_scl    = 1'b1;
        frame_rw   = 1'b0;
        frame_nack = 1'b0;
        no_idle    = 1'b0;
        items_sent = 0;
        idle_cycles = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: all clear, all set, each field alone, contradictory edges
        send_item('0);
        it = '1;
        it.pad = '0;
        send_item(it);
        for (int f = 0; f < 9; f++)
            send_item(in_item_t'(16'(1) << f));
        // both sda edges with scl high: start and stop at once
        it = '0;
        it.scl_level = 1'b1;
        it.sda_rise  = 1'b1;
        it.sda_fall  = 1'b1;
        send_item(it);
        // both scl edges at once
        it = '0;
        it.scl_rise = 1'b1;
        it.scl_fall = 1'b1;
        send_item(it);
        // soft clear together with a start
        it = '0;
        it.scl_level  = 1'b1;
        it.sda_fall   = 1'b1;
        it.soft_clear = 1'b1;
        send_item(it);
        // bring the model back to a known bus
        it = '0;
        it.sda_level  = 1'b1;
        it.scl_level  = 1'b1;
        it.soft_clear = 1'b1;
        send_item(it);

        // random part
        while (items_sent < NUM_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 19);
            if (pick < 15) begin
                // a frame: start, address byte, data bytes, stop or repeated start
                frame_rw   = 1'($urandom_range(0, 1));
                frame_nack = ($urandom_range(0, 4) == 0);
                broken     = ($urandom_range(0, 3) == 0);
                nbytes     = $urandom_range(1, 4);
                total_bits = nbytes * 9;
                abort_at   = $urandom_range(0, total_bits - 1);
                if (bus_scl && !bus_sda) drive_bus(1'b0, 1'b0);
                if (!bus_sda) drive_bus(1'b1, 1'b0);
                if (!bus_scl) drive_bus(1'b1, 1'b1);
                drive_bus(1'b0, 1'b1);
                for (int i = 0; i < total_bits; i++) begin
                    drive_bus(bus_sda, 1'b0);
                    if (broken && i == abort_at) begin
                        // cut the frame short with a start or a stop
                        if ($urandom_range(0, 1) != 0) begin
                            drive_bus(1'b1, 1'b0);
                            drive_bus(1'b1, 1'b1);
                            drive_bus(1'b0, 1'b1);
                        end else begin
                            drive_bus(1'b0, 1'b0);
                            drive_bus(1'b0, 1'b1);
                            drive_bus(1'b1, 1'b1);
                        end
                        break;
                    end
                    // ack bit mostly low so reads keep going
                    if (i % 9 == 8) bit_val = ($urandom_range(0, 3) == 0);
                    else bit_val = 1'($urandom_range(0, 1));
                    drive_bus(bit_val, 1'b0);
                    drive_bus(bit_val, 1'b1);
                end
                if (!broken && $urandom_range(0, 4) != 0) begin
                    drive_bus(1'b0, 1'b0);
                    drive_bus(1'b0, 1'b0);
                    drive_bus(1'b0, 1'b1);
                    drive_bus(1'b1, 1'b1);
                end
            end else if (pick < 17) begin
                // unstructured noise
                n = $urandom_range(4, 16);
                repeat (n) begin
                    it            = in_item_t'(16'($urandom));
                    it.pad        = '0;
                    it.soft_clear = ($urandom_range(0, 15) == 0);
                    bus_sda = it.sda_level;
                    bus_scl = it.scl_level;
                    send_item(it);
                end
            end else if (pick < 18) begin
                // scl falls with no rises: the bit counter runs past 15
                n = $urandom_range(17, 20);
                repeat (n) begin
                    it           = '0;
                    it.sda_level = bus_sda;
                    it.scl_level = bus_scl;
                    it.scl_fall  = 1'b1;
                    it.rw_bit    = 1'($urandom_range(0, 1));
                    send_item(it);
                end
            end else begin
                // free clocking with no start
                frame_rw   = 1'($urandom_range(0, 1));
                frame_nack = 1'($urandom_range(0, 1));
                n = $urandom_range(10, 30);
                repeat (n) begin
                    drive_bus(bus_sda, 1'b0);
                    drive_bus(1'($urandom_range(0, 1)), 1'b0);
                    drive_bus(bus_sda, 1'b1);
                end
            end
        end
        s_tvalid <= 1'b0;

        // drain, then a few more cycles for stray results
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
